### rtl/assert_macros.svh
// Assertion macros shared by the rational arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RAU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define RAU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/rau_pkg.sv
// Shared constants and types of the rational arithmetic unit.
package rau_pkg;
	localparam int OPW     = 16;
	localparam int DMW     = 2 * OPW - 1;
	localparam int NMW     = 2 * OPW;
	localparam int STEPS   = NMW + DMW;
	localparam int KW      = $clog2(NMW) + 1;
	localparam int NUMOUTW = 33;
	localparam int DENOUTW = 32;
	localparam int WIDEW   = NMW + NUMOUTW;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
	localparam logic [1:0] ST_ZERO_ZERO = 2'd2;

	typedef struct packed {
		logic [1:0]            operation;
		logic signed [OPW-1:0] a_num;
		logic signed [OPW-1:0] a_den;
		logic signed [OPW-1:0] b_num;
		logic signed [OPW-1:0] b_den;
	} rau_req_t;

	typedef struct packed {
		logic signed [NUMOUTW-1:0] result_num;
		logic signed [DENOUTW-1:0] result_den;
		logic [1:0]                status;
	} rau_rsp_t;

	typedef struct packed {
		logic [1:0]     status;
		logic           num_neg;
		logic [NMW-1:0] num_mag;
		logic           den_neg;
		logic [NMW-1:0] den_mag;
	} rau_frac_t;

	typedef struct packed {
		rau_frac_t      frac;
		logic [NMW-1:0] g;
	} rau_red_t;
endpackage

### rtl/rau_front.sv
// Operand conversion, cross products and numerator sum over two stages.
module rau_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  rau_pkg::rau_req_t  req,
	output logic               out_valid,
	output rau_pkg::rau_frac_t frac
);
	function automatic logic [rau_pkg::OPW-1:0] mag_of(logic [rau_pkg::OPW-1:0] v);
		return v[rau_pkg::OPW-1] ? (~v + 1'b1) : v;
	endfunction

	logic [rau_pkg::OPW-1:0]   an, ad, bn, bd, x0, y0, y2;
	logic                      an_s, ad_s, bn_s, bd_s, bn_e, sx0, sy0, sy2;
	logic [rau_pkg::NMW-1:0]   pr0, pr1, pr2;

	logic                      valid_s1, addsub_s1;
	logic [1:0]                status_s1;
	logic [rau_pkg::DMW-1:0]   p0_s1, p1_s1, pd_s1;
	logic                      p0n_s1, p1n_s1, pdn_s1;

	logic [rau_pkg::NMW-1:0]   a0, a1, sum;
	logic                      sum_neg;
	rau_pkg::rau_frac_t        nxt;

	always_comb begin
		an = mag_of(req.a_num);
		ad = mag_of(req.a_den);
		bn = mag_of(req.b_num);
		bd = mag_of(req.b_den);
		an_s = req.a_num[rau_pkg::OPW-1];
		ad_s = req.a_den[rau_pkg::OPW-1];
		bn_s = req.b_num[rau_pkg::OPW-1];
		bd_s = req.b_den[rau_pkg::OPW-1];
		bn_e = (req.operation == rau_pkg::OP_SUB) ? ~bn_s : bn_s;
		x0 = an;
		sx0 = an_s;
		if (req.operation == rau_pkg::OP_MUL) begin
			y0 = bn;
			sy0 = bn_s;
		end else begin
			y0 = bd;
			sy0 = bd_s;
		end
		if (req.operation == rau_pkg::OP_DIV) begin
			y2 = bn;
			sy2 = bn_s;
		end else begin
			y2 = bd;
			sy2 = bd_s;
		end
		pr0 = x0 * y0;
		pr1 = bn * ad;
		pr2 = ad * y2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			addsub_s1 <= (req.operation == rau_pkg::OP_ADD) || (req.operation == rau_pkg::OP_SUB);
			status_s1 <= ((req.operation == rau_pkg::OP_DIV) && (bn == '0)) ?
				rau_pkg::ST_DIV_ZERO : rau_pkg::ST_OK;
			p0_s1  <= pr0[rau_pkg::DMW-1:0];
			p1_s1  <= pr1[rau_pkg::DMW-1:0];
			pd_s1  <= pr2[rau_pkg::DMW-1:0];
			p0n_s1 <= (pr0 != '0) && (sx0 ^ sy0);
			p1n_s1 <= (pr1 != '0) && (bn_e ^ ad_s);
			pdn_s1 <= (pr2 != '0) && (ad_s ^ sy2);
		end
	end

	always_comb begin
		a0 = {1'b0, p0_s1};
		a1 = {1'b0, p1_s1};
		if (!addsub_s1) begin
			sum = a0;
			sum_neg = p0n_s1;
		end else if (p0n_s1 == p1n_s1) begin
			sum = a0 + a1;
			sum_neg = p0n_s1;
		end else if (a0 >= a1) begin
			sum = a0 - a1;
			sum_neg = p0n_s1;
		end else begin
			sum = a1 - a0;
			sum_neg = p1n_s1;
		end
		nxt.num_mag = sum;
		nxt.num_neg = sum_neg && (sum != '0);
		nxt.den_mag = {1'b0, pd_s1};
		nxt.den_neg = pdn_s1;
		if (status_s1 != rau_pkg::ST_OK) begin
			nxt.status = status_s1;
		end else if ((sum == '0) && (pd_s1 == '0)) begin
			nxt.status = rau_pkg::ST_ZERO_ZERO;
		end else begin
			nxt.status = rau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frac <= nxt;
		end
	end
endmodule

### rtl/rau_gcd.sv
// Pipelined binary GCD, one reduction step per stage, then the common power of two.
module rau_gcd (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  rau_pkg::rau_frac_t frac,
	output logic               out_valid,
	output rau_pkg::rau_red_t  red
);
	typedef struct packed {
		logic [rau_pkg::NMW-1:0] u;
		logic [rau_pkg::NMW-1:0] v;
		logic [rau_pkg::KW-1:0]  k;
	} gst_t;

	function automatic gst_t gcd_step(gst_t s);
		gst_t r;
		r = s;
		if ((s.u != '0) && (s.v != '0)) begin
			if (!s.u[0] && !s.v[0]) begin
				r.u = s.u >> 1;
				r.v = s.v >> 1;
				r.k = s.k + 1'b1;
			end else if (!s.u[0]) begin
				r.u = s.u >> 1;
			end else if (!s.v[0]) begin
				r.v = s.v >> 1;
			end else if (s.u >= s.v) begin
				r.u = (s.u - s.v) >> 1;
			end else begin
				r.v = (s.v - s.u) >> 1;
			end
		end
		return r;
	endfunction

	logic [rau_pkg::STEPS-1:0] vld_q;
	gst_t                      st_q [rau_pkg::STEPS];
	rau_pkg::rau_frac_t        fr_q [rau_pkg::STEPS];

	for (genvar j = 0; j < rau_pkg::STEPS; j++) begin : g_step
		logic               cur_v;
		gst_t               cur_st;
		rau_pkg::rau_frac_t cur_fr;
		if (j == 0) begin : g_first
			assign cur_v  = in_valid;
			assign cur_st = '{u: frac.num_mag, v: frac.den_mag, k: '0};
			assign cur_fr = frac;
		end else begin : g_next
			assign cur_v  = vld_q[j-1];
			assign cur_st = st_q[j-1];
			assign cur_fr = fr_q[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (adv) begin
				vld_q[j] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_q[j] <= gcd_step(cur_st);
				fr_q[j] <= cur_fr;
			end
		end
	end

	gst_t last;
	assign last = st_q[rau_pkg::STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_q[rau_pkg::STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red.frac <= fr_q[rau_pkg::STEPS-1];
			red.g    <= (last.u | last.v) << last.k;
		end
	end
endmodule

### rtl/rau_div.sv
// Two restoring dividers side by side, one quotient bit per stage, and result packing.
module rau_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  rau_pkg::rau_red_t red,
	output logic              out_valid,
	output rau_pkg::rau_rsp_t rsp
);
	typedef struct packed {
		logic [rau_pkg::NMW-1:0] rn;
		logic [rau_pkg::NMW-1:0] qn;
		logic [rau_pkg::NMW-1:0] rd;
		logic [rau_pkg::NMW-1:0] qd;
	} dst_t;

	function automatic logic [2*rau_pkg::NMW-1:0] div_bit(
		logic [rau_pkg::NMW-1:0] r,
		logic [rau_pkg::NMW-1:0] q,
		logic [rau_pkg::NMW-1:0] d
	);
		logic [rau_pkg::NMW:0] rw;
		logic                  ge;
		rw = {r, q[rau_pkg::NMW-1]};
		ge = rw >= {1'b0, d};
		if (ge) begin
			rw = rw - {1'b0, d};
		end
		return {rw[rau_pkg::NMW-1:0], q[rau_pkg::NMW-2:0], ge};
	endfunction

	logic [rau_pkg::NMW-1:0] vld_q;
	dst_t                    ds_q [rau_pkg::NMW];
	rau_pkg::rau_red_t       rd_q [rau_pkg::NMW];

	for (genvar j = 0; j < rau_pkg::NMW; j++) begin : g_bit
		logic              cur_v;
		dst_t              cur_ds;
		rau_pkg::rau_red_t cur_rd;
		if (j == 0) begin : g_first
			assign cur_v  = in_valid;
			assign cur_ds = '{rn: '0, qn: red.frac.num_mag, rd: '0, qd: red.frac.den_mag};
			assign cur_rd = red;
		end else begin : g_next
			assign cur_v  = vld_q[j-1];
			assign cur_ds = ds_q[j-1];
			assign cur_rd = rd_q[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (adv) begin
				vld_q[j] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				{ds_q[j].rn, ds_q[j].qn} <= div_bit(cur_ds.rn, cur_ds.qn, cur_rd.g);
				{ds_q[j].rd, ds_q[j].qd} <= div_bit(cur_ds.rd, cur_ds.qd, cur_rd.g);
				rd_q[j] <= cur_rd;
			end
		end
	end

	logic [rau_pkg::WIDEW-1:0] wn, wd;
	rau_pkg::rau_frac_t        fl;

	always_comb begin
		fl = rd_q[rau_pkg::NMW-1].frac;
		wn = {{(rau_pkg::WIDEW-rau_pkg::NMW){1'b0}}, ds_q[rau_pkg::NMW-1].qn};
		wd = {{(rau_pkg::WIDEW-rau_pkg::NMW){1'b0}}, ds_q[rau_pkg::NMW-1].qd};
		if (fl.num_neg) begin
			wn = -wn;
		end
		if (fl.den_neg) begin
			wd = -wd;
		end
		rsp.status = fl.status;
		if (fl.status == rau_pkg::ST_OK) begin
			rsp.result_num = wn[rau_pkg::NUMOUTW-1:0];
			rsp.result_den = wd[rau_pkg::DENOUTW-1:0];
		end else begin
			rsp.result_num = '0;
			rsp.result_den = '0;
		end
	end

	assign out_valid = vld_q[rau_pkg::NMW-1];
endmodule

### rtl/rational_arith_unit_core.sv
// Top level of the rational arithmetic unit: front end, GCD pipeline and dividers.
// Throughput: one transaction per cycle; every stage is a register and the pipeline
// advances as a whole whenever the response register is empty or being taken.
// Reset: arst_n clears every valid bit at once; data registers are not reset.
`include "assert_macros.svh"
module rational_arith_unit_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rau_pkg::rau_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rau_pkg::rau_rsp_t rsp
);
	// The whole pipeline moves one step when the final stage can hand on its
	// transaction, so a stall freezes every stage in place and nothing is lost
	// or repeated.
	logic               adv;
	logic               fr_valid, gcd_valid;
	rau_pkg::rau_frac_t frac;
	rau_pkg::rau_red_t  red;

	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;

	// Signs and magnitudes, the three cross products, then the numerator sum
	// and the error classification.
	rau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (req_valid),
		.req       (req),
		.out_valid (fr_valid),
		.frac      (frac)
	);

	// Binary GCD of the two magnitudes, fully unrolled into stages.
	rau_gcd u_gcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (fr_valid),
		.frac      (frac),
		.out_valid (gcd_valid),
		.red       (red)
	);

	// Both parts divided by the GCD, signs restored and wrapped to the
	// response widths; the last divider stage is the response register.
	rau_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (gcd_valid),
		.red       (red),
		.out_valid (rsp_valid),
		.rsp       (rsp)
	);

	`RAU_ASSERT(a_rsp_held, clk, arst_n, (rsp_valid && !rsp_ready) |=> rsp_valid, "Response dropped while stalled.")
	`RAU_ASSERT_NEVER(a_status_code, clk, arst_n, rsp_valid && (rsp.status != rau_pkg::ST_OK) && (rsp.status != rau_pkg::ST_DIV_ZERO) && (rsp.status != rau_pkg::ST_ZERO_ZERO), "Undefined status code.")
	`RAU_ASSERT(a_err_zero, clk, arst_n, (rsp_valid && (rsp.status != rau_pkg::ST_OK)) |-> ((rsp.result_num == '0) && (rsp.result_den == '0)), "Error response carries a value.")
	`RAU_ASSERT(a_zero_num, clk, arst_n, (rsp_valid && (rsp.status == rau_pkg::ST_OK) && (rsp.result_num == '0)) |-> ((rsp.result_den == 32'sd1) || (rsp.result_den == -32'sd1)), "Zero result not reduced to unit denominator.")
endmodule

### sim/tb.sv
// Self-checking testbench of the rational arithmetic unit with a scoreboard of expected fractions.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Scoreboard: computes the reduced fraction for each accepted request and
	// holds the expectations in order of acceptance.
	class fraction_scoreboard;
		rau_pkg::rau_rsp_t pending_fractions[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Works out the exact, reduced fraction in two's complement form.
		function rau_pkg::rau_rsp_t reduce_fraction(rau_pkg::rau_req_t r);
			rau_pkg::rau_rsp_t e;
			longint an, ad, bn, bd, num, den, x, y, t;
			an = r.a_num;
			ad = r.a_den;
			bn = r.b_num;
			bd = r.b_den;
			e = '0;
			case (r.operation)
				rau_pkg::OP_ADD: begin
					num = an * bd + bn * ad;
					den = ad * bd;
				end
				rau_pkg::OP_SUB: begin
					num = an * bd - bn * ad;
					den = ad * bd;
				end
				rau_pkg::OP_MUL: begin
					num = an * bn;
					den = ad * bd;
				end
				default: begin
					if (bn == 0) begin
						e.status = rau_pkg::ST_DIV_ZERO;
						return e;
					end
					num = an * bd;
					den = ad * bn;
				end
			endcase
			x = (num < 0) ? -num : num;
			y = (den < 0) ? -den : den;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			if (x == 0) begin
				e.status = rau_pkg::ST_ZERO_ZERO;
				return e;
			end
			num = num / x;
			den = den / x;
			e.result_num = num[rau_pkg::NUMOUTW-1:0];
			e.result_den = den[rau_pkg::DENOUTW-1:0];
			e.status = rau_pkg::ST_OK;
			return e;
		endfunction

		function void note_request(rau_pkg::rau_req_t r);
			pending_fractions.push_back(reduce_fraction(r));
		endfunction

		function void check_response(rau_pkg::rau_rsp_t got);
			rau_pkg::rau_rsp_t want;
			if (pending_fractions.size() == 0) begin
				$display("%0t: unexpected response %h", $realtime, got);
				errors++;
				return;
			end
			want = pending_fractions.pop_front();
			if (got.result_num !== want.result_num) begin
				$display("%0t: result_num expected %0d actual %0d", $realtime,
					want.result_num, got.result_num);
				errors++;
			end
			if (got.result_den !== want.result_den) begin
				$display("%0t: result_den expected %0d actual %0d", $realtime,
					want.result_den, got.result_den);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $realtime,
					want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	localparam int LATENCY = 98;
	localparam longint CYCLE_LIMIT = 400000;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	rau_pkg::rau_req_t req;
	logic              rsp_valid;
	logic              rsp_ready;
	rau_pkg::rau_rsp_t rsp;

	fraction_scoreboard sb;
	longint cycle_count;
	bit     calm_stretch;  // no idling on either side while set
	bit     hold_receiver; // long receiver hold-off to fill the pipeline

	rational_arith_unit_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Operand picker biased towards the edges of the 16-bit range.
	function automatic logic [15:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'h0001;
			4: return 16'hffff;
			5: return 16'($signed($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	// Presents one request transaction and waits until it has been accepted.
	// Valid is dropped only in idle cycles, so back-to-back transactions keep it high.
	task automatic send_request(input rau_pkg::rau_req_t r);
		while (!calm_stretch && $urandom_range(0, 99) < 31) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic send_fields(input logic [1:0] op, input logic [15:0] an,
			input logic [15:0] ad, input logic [15:0] bn, input logic [15:0] bd);
		rau_pkg::rau_req_t r;
		r.operation = op;
		r.a_num = an;
		r.a_den = ad;
		r.b_num = bn;
		r.b_den = bd;
		send_request(r);
	endtask

	// Receiver: ready is redrawn every cycle and the response checked on acceptance.
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
			rsp_ready <= !hold_receiver && (calm_stretch || $urandom_range(0, 99) >= 31);
		end
	end

	// Cycle counter: ends the run if it runs far beyond the slowest correct run.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Receiver hold-off counted in its own process while requests keep coming.
	task automatic hold_off_receiver(input int cycles);
		hold_receiver = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_receiver = 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		calm_stretch = 1'b0;
		hold_receiver = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: every operation, range extremes and the special cases.
		send_fields(rau_pkg::OP_ADD, 16'h0001, 16'h0002, 16'h0001, 16'h0003);
		send_fields(rau_pkg::OP_SUB, 16'h0001, 16'h0002, 16'h0001, 16'h0002);
		send_fields(rau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_fields(rau_pkg::OP_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		send_fields(rau_pkg::OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_fields(rau_pkg::OP_SUB, 16'h8000, 16'h0001, 16'h7fff, 16'h0001);
		send_fields(rau_pkg::OP_ADD, 16'h8000, 16'h8001, 16'h8000, 16'h7fff);
		// Divide by zero.
		send_fields(rau_pkg::OP_DIV, 16'h0005, 16'h0003, 16'h0000, 16'h0007);
		send_fields(rau_pkg::OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// Zero over zero.
		send_fields(rau_pkg::OP_MUL, 16'h0000, 16'h0000, 16'h0003, 16'h0004);
		send_fields(rau_pkg::OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// Zero numerator with either sign of denominator.
		send_fields(rau_pkg::OP_MUL, 16'h0000, 16'h0003, 16'h0005, 16'hfffb);
		send_fields(rau_pkg::OP_SUB, 16'h0002, 16'h0003, 16'h0002, 16'h0003);
		send_fields(rau_pkg::OP_DIV, 16'h0000, 16'h0005, 16'h0003, 16'h0004);
		// Zero operand denominators, then all operands at minus one.
		send_fields(rau_pkg::OP_MUL, 16'hfff9, 16'h0000, 16'h0003, 16'h0004);
		send_fields(rau_pkg::OP_ADD, 16'h0003, 16'h0000, 16'h0002, 16'h0005);
		send_fields(rau_pkg::OP_DIV, 16'h0006, 16'h0004, 16'hfffd, 16'h0000);
		send_fields(rau_pkg::OP_MUL, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

		// Long receiver hold-off while the sender keeps offering requests.
		fork
			hold_off_receiver(400);
			repeat (150)
				send_fields(2'($urandom), pick_operand(), pick_operand(),
					pick_operand(), pick_operand());
		join

		// Random part, with a stretch of no idling in the middle.
		for (int i = 0; i < 850; i++) begin
			calm_stretch = (i >= 300 && i < 450);
			send_fields(2'($urandom), pick_operand(), pick_operand(),
				pick_operand(), pick_operand());
		end
		calm_stretch = 1'b0;
		req_valid <= 1'b0;

		while (sb.pending_fractions.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
